### rtl/dlfo_pkg.sv
// Shared types and constants of the dual LFO with sync delay.
package dlfo_pkg;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int DELAY_BITS     = 24;
   localparam int RATE_BITS      = 16;
   localparam int RATE_FRAC_BITS = 15;

   // Register map of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLES     = 3'd0,
      CSR_PITCH_WAVE  = 3'd1,
      CSR_AMP_WAVE    = 3'd2,
      CSR_PITCH_STEP  = 3'd3,
      CSR_AMP_STEP    = 3'd4,
      CSR_SYNC_MODE   = 3'd5,
      CSR_DELAY_TICKS = 3'd6,
      CSR_SMOOTH_RATE = 3'd7
   } csr_index_type;

   // Wave codes; the remaining codes give zero, six and seven are one-shot
   localparam logic [2:0] WAVE_SAW       = 3'd0;
   localparam logic [2:0] WAVE_SQUARE    = 3'd1;
   localparam logic [2:0] WAVE_TRIANGLE  = 3'd2;
   localparam logic [2:0] WAVE_NOISE     = 3'd3;
   localparam logic [2:0] WAVE_ONESHOT_A = 3'd6;
   localparam logic [2:0] WAVE_ONESHOT_B = 3'd7;

   localparam logic [1:0] SYNC_FREE = 2'd0;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_NOTE = 1'b1;

   localparam logic [RATE_BITS-1:0] RATE_UNITY = 16'd32768;

   typedef struct packed {
      logic [1:0]               enables;
      logic [2:0]               pitch_wave;
      logic [2:0]               amp_wave;
      logic [CSR_DATA_BITS-1:0] pitch_step;
      logic [CSR_DATA_BITS-1:0] amp_step;
      logic [1:0]               sync_mode;
      logic [DELAY_BITS-1:0]    delay_ticks;
      logic [RATE_BITS-1:0]     smooth_rate;
   } csr_type;

endpackage

### rtl/dlfo_osc.sv
// Phase accumulators, sync delay, noise hold and wave shaping, with the stage register.
module dlfo_osc
   import dlfo_pkg::*;
#(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csr_type                       csr,
   input  logic                          take,
   input  logic                          cmd,
   input  logic signed [SAMPLE_BITS-1:0] noise,
   input  logic                          drain,
   output logic                          s1_valid,
   output logic signed [SAMPLE_BITS-1:0] s1_pitch,
   output logic        [SAMPLE_BITS-1:0] s1_target
);

   localparam int PB = PHASE_BITS;
   localparam int S  = SAMPLE_BITS;
   localparam int TW = SAMPLE_BITS + 3;

   localparam logic [S-1:0]          MAX_S  = {1'b0, {(S-1){1'b1}}};
   localparam logic [S-1:0]          MIN_S  = {1'b1, {(S-1){1'b0}}};
   localparam logic [S-1:0]          FULL_S = {1'b1, {(S-1){1'b0}}};
   localparam logic signed [TW-1:0]  FULL_W = {3'b000, 1'b1, {(S-1){1'b0}}};

   logic [PB-1:0]         pitch_phase_ff, pitch_phase_in;
   logic [PB-1:0]         amp_phase_ff, amp_phase_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic signed [S-1:0]   held_ff, held_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic signed [S-1:0]   pitch_ff, pitch_in;
   logic [S-1:0]          target_ff, target_in;

   logic [PB+CSR_DATA_BITS-1:0] pstep_wide, astep_wide;
   logic [PB-1:0]         pstep, astep;
   logic [PB:0]           psum, asum;
   logic [DELAY_BITS-1:0] delay_dec;
   logic                  run, adv, wrap, oneshot;
   logic [PB-1:0]         pitch_next, amp_next;
   logic signed [S-1:0]   held_now;
   logic [PB+S-1:0]       pitch_ext, amp_ext;
   logic [S-1:0]          ptop;
   logic [S-2:0]          pa;
   logic signed [TW-1:0]  two_p, tri_raw;
   logic [S-1:0]          tri_sat;
   logic [S-1:0]          pitch_shape, amp_shape;

   // Step registers are 32 bits; fit them to the phase width
   assign pstep_wide = {{PB{1'b0}}, csr.pitch_step};
   assign astep_wide = {{PB{1'b0}}, csr.amp_step};
   assign pstep      = pstep_wide[PB-1:0];
   assign astep      = astep_wide[PB-1:0];
   assign psum       = {1'b0, pitch_phase_ff} + {1'b0, pstep};
   assign asum       = {1'b0, amp_phase_ff} + {1'b0, astep};

   assign delay_dec  = (delay_ff != '0) ? delay_ff - 1'b1 : '0;
   assign run        = (csr.enables != 2'b00);
   assign adv        = run && (delay_dec == '0);
   assign pitch_next = adv ? psum[PB-1:0] : pitch_phase_ff;
   assign amp_next   = adv ? asum[PB-1:0] : amp_phase_ff;
   assign wrap       = adv && (psum[PB] || asum[PB]);
   assign held_now   = wrap ? noise : held_ff;

   assign oneshot = (csr.pitch_wave == WAVE_ONESHOT_A) || (csr.pitch_wave == WAVE_ONESHOT_B)
                 || (csr.amp_wave == WAVE_ONESHOT_A) || (csr.amp_wave == WAVE_ONESHOT_B);

   // Top bits of each phase; a narrow phase is padded with zeros below
   assign pitch_ext = {pitch_next, {S{1'b0}}};
   assign amp_ext   = {amp_next, {S{1'b0}}};
   assign ptop      = pitch_ext[PB+S-1 -: S];
   assign pa        = amp_ext[PB+S-1 -: S-1];

   assign two_p = $signed({2'b00, ptop, 1'b0});

   always_comb begin
      unique case (ptop[S-1:S-2])
         2'b00:        tri_raw = two_p;
         2'b01, 2'b10: tri_raw = (FULL_W <<< 1) - two_p;
         2'b11:        tri_raw = two_p - (FULL_W <<< 2);
      endcase
      if (tri_raw >= FULL_W) begin
         tri_sat = MAX_S;
      end else if (tri_raw < -FULL_W) begin
         tri_sat = MIN_S;
      end else begin
         tri_sat = tri_raw[S-1:0];
      end
   end

   always_comb begin
      unique case (csr.pitch_wave)
         WAVE_SAW:      pitch_shape = ptop;
         WAVE_SQUARE:   pitch_shape = ptop[S-1] ? MIN_S : MAX_S;
         WAVE_TRIANGLE: pitch_shape = tri_sat;
         WAVE_NOISE:    pitch_shape = held_now;
         default:       pitch_shape = '0;
      endcase
   end

   always_comb begin
      unique case (csr.amp_wave)
         WAVE_SAW:      amp_shape = FULL_S - {1'b0, pa};
         WAVE_SQUARE:   amp_shape = pa[S-2] ? '0 : FULL_S;
         WAVE_TRIANGLE: amp_shape = pa[S-2] ? ({pa, 1'b0} - FULL_S) : (FULL_S - {pa, 1'b0});
         WAVE_NOISE:    amp_shape = {1'b0, ~held_now[S-1], held_now[S-2:1]};
         default:       amp_shape = '0;
      endcase
   end

   always_comb begin
      pitch_phase_in = pitch_phase_ff;
      amp_phase_in   = amp_phase_ff;
      delay_in       = delay_ff;
      held_in        = held_ff;
      if (take) begin
         if (cmd == CMD_NOTE) begin
            if ((csr.sync_mode != SYNC_FREE) || oneshot) begin
               pitch_phase_in = '0;
               amp_phase_in   = '0;
            end
            // sync mode three behaves as two
            delay_in = csr.sync_mode[1] ? csr.delay_ticks : '0;
         end else if (run) begin
            delay_in       = delay_dec;
            pitch_phase_in = pitch_next;
            amp_phase_in   = amp_next;
            held_in        = held_now;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      pitch_in    = pitch_ff;
      target_in   = target_ff;
      if (take && (cmd == CMD_TICK)) begin
         s1_valid_in = 1'b1;
         pitch_in    = adv ? pitch_shape : '0;
         target_in   = adv ? amp_shape : '0;
      end else if (drain) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_phase_ff <= '0;
         amp_phase_ff   <= '0;
         delay_ff       <= '0;
         held_ff        <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         pitch_phase_ff <= pitch_phase_in;
         amp_phase_ff   <= amp_phase_in;
         delay_ff       <= delay_in;
         held_ff        <= held_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff  <= pitch_in;
      target_ff <= target_in;
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_pitch  = pitch_ff;
   assign s1_target = target_ff;

endmodule

### rtl/dlfo_smooth.sv
// One-pole amplitude smoother and result register.
module dlfo_smooth
   import dlfo_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] s1_pitch,
   input  logic        [SAMPLE_BITS-1:0] s1_target,
   input  logic        [RATE_BITS-1:0]   smooth_rate,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_pitch_value,
   output logic        [SAMPLE_BITS-1:0] rsp_amp_value
);

   localparam int S  = SAMPLE_BITS;
   localparam int PW = SAMPLE_BITS + RATE_BITS + 2;

   localparam logic signed [PW-1:0] ROUND_BIAS = PW'((1 << RATE_FRAC_BITS) - 1);

   logic [S-1:0]              smooth_ff, smooth_in;
   logic                      valid_ff, valid_in;
   logic signed [S-1:0]       pitch_ff, pitch_in;

   logic [RATE_BITS-1:0]      rate_sat;
   logic signed [RATE_BITS:0] rate_s;
   logic signed [S:0]         diff;
   logic signed [PW-1:0]      prod, prod_adj, delta;
   logic [S:0]                sum;

   assign rate_sat = (smooth_rate > RATE_UNITY) ? RATE_UNITY : smooth_rate;
   assign rate_s   = $signed({1'b0, rate_sat});
   assign diff     = $signed({1'b0, s1_target}) - $signed({1'b0, smooth_ff});
   assign prod     = PW'(diff) * PW'(rate_s);
   // bias negative products so the shift rounds toward zero
   assign prod_adj = prod + (prod[PW-1] ? ROUND_BIAS : '0);
   assign delta    = prod_adj >>> RATE_FRAC_BITS;
   assign sum      = {1'b0, smooth_ff} + delta[S:0];

   always_comb begin
      smooth_in = smooth_ff;
      pitch_in  = pitch_ff;
      valid_in  = valid_ff;
      if (load) begin
         smooth_in = sum[S-1:0];
         pitch_in  = s1_pitch;
         valid_in  = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         smooth_ff <= smooth_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pitch_value = pitch_ff;
   assign rsp_amp_value   = smooth_ff;

endmodule

### rtl/dual_lfo_with_sync_delay_unit.sv
// Top level of the dual LFO with sync delay: configuration registers and the two stages.
//
// Input channel req_*: one item per handshake. req_cmd low is a sample tick, high a
// note-on; req_noise is sampled into the noise hold when either phase wraps on a tick.
// Result channel rsp_*: one item for each tick, none for a note-on. rsp_pitch_value is
// signed Q1.15, rsp_amp_value the smoothed amplitude, unsigned Q15 from 0 to 32768.
// Configuration port csr_*: csr_index picks the register, csr_data carries the value;
// csr_ready is always high. Write only while no item is in flight.
// A tick accepted at the input is registered in the first stage, then in the result
// register of the second. Throughput is one item per cycle while results are taken, set
// by the phase accumulators in the first stage and the smoother in the second.
// A stalled receiver holds the result register; the first stage still takes note-ons
// and one more tick, after which req_ready drops until the result is taken.
// Reset clears phases, sync delay, noise hold, smoother, valid flags and configuration
// registers, except the smoothing rate, which comes up at 32768 (no smoothing).
module dual_lfo_with_sync_delay_unit
   import dlfo_pkg::*;
#(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_noise,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_pitch_value,
   output logic        [SAMPLE_BITS-1:0] rsp_amp_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam logic [SAMPLE_BITS-1:0] FULL_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam csr_type CSR_RESET = '{
      enables:     '0,
      pitch_wave:  '0,
      amp_wave:    '0,
      pitch_step:  '0,
      amp_step:    '0,
      sync_mode:   '0,
      delay_ticks: '0,
      smooth_rate: RATE_UNITY
   };

   csr_type csr_ff, csr_in;

   logic                          take, drain, s2_free;
   logic                          s1_valid;
   logic signed [SAMPLE_BITS-1:0] s1_pitch;
   logic        [SAMPLE_BITS-1:0] s1_target;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLES:     csr_in.enables     = csr_data[1:0];
            CSR_PITCH_WAVE:  csr_in.pitch_wave  = csr_data[2:0];
            CSR_AMP_WAVE:    csr_in.amp_wave    = csr_data[2:0];
            CSR_PITCH_STEP:  csr_in.pitch_step  = csr_data;
            CSR_AMP_STEP:    csr_in.amp_step    = csr_data;
            CSR_SYNC_MODE:   csr_in.sync_mode   = csr_data[1:0];
            CSR_DELAY_TICKS: csr_in.delay_ticks = csr_data[DELAY_BITS-1:0];
            CSR_SMOOTH_RATE: csr_in.smooth_rate = csr_data[RATE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Second stage frees when its result leaves; the first drains into it
   assign s2_free   = !rsp_valid || rsp_ready;
   assign drain     = s1_valid && s2_free;
   assign req_ready = !s1_valid || s2_free;
   assign take      = req_valid && req_ready;

   dlfo_osc #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_osc (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .take      (take),
      .cmd       (req_cmd),
      .noise     (req_noise),
      .drain     (drain),
      .s1_valid  (s1_valid),
      .s1_pitch  (s1_pitch),
      .s1_target (s1_target)
   );

   dlfo_smooth #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_smooth (
      .clock           (clock),
      .reset           (reset),
      .load            (drain),
      .s1_pitch        (s1_pitch),
      .s1_target       (s1_target),
      .smooth_rate     (csr_ff.smooth_rate),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_pitch_value (rsp_pitch_value),
      .rsp_amp_value   (rsp_amp_value)
   );

   // A note-on into an empty first stage leaves it empty
   a_note_no_item: assert property (@(posedge clock) disable iff (reset)
      take && (req_cmd == CMD_NOTE) && !s1_valid |=> !s1_valid)
      else $error("note-on produced a pending item");

   // Input stalls only when both stages are full and the receiver holds off
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid && rsp_valid && !rsp_ready)
      else $error("input stalled without a full pipeline");

   // Smoothed amplitude never leaves its range
   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_amp_value <= FULL_S)
      else $error("amplitude above full scale");

endmodule

### tb/dual_lfo_with_sync_delay_unit_tb.sv
// Self-checking testbench of the dual LFO with sync delay: tick and note-on stimulus, bit-exact prediction.
module dual_lfo_with_sync_delay_unit_tb;
   import dlfo_pkg::*;

   localparam int        FULL_SCALE   = 32768;
   localparam int        CYCLE_LIMIT  = 400000;
   localparam int        RANDOM_SETS  = 12;
   localparam int        SET_ITEMS    = 69;
   localparam logic [1:0] SYNC_ON_NOTE = 2'd1;
   localparam logic [1:0] SYNC_DELAYED = 2'd2;
   localparam logic [1:0] SYNC_SPARE   = 2'd3;

   typedef struct {
      logic                cmd;
      logic signed [15:0] noise;
   } lfo_req_t;

   typedef struct {
      logic [15:0] pitch;
      logic [15:0] amp;
   } lfo_mod_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = CMD_TICK;
   logic signed [15:0] req_noise = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_pitch_value;
   logic        [15:0] rsp_amp_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   lfo_req_t req_pending[$];
   lfo_mod_t mod_expected[$];

   // Predicted state of the oscillator
   csr_type            lfo_cfg;
   logic [31:0]        pitch_acc = '0;
   logic [31:0]        amp_acc = '0;
   logic [23:0]        sync_wait = '0;
   logic signed [15:0] noise_hold = '0;
   int                 amp_level = 0;

   int mismatches = 0;
   int cycles = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit calm = 1'b0;
   bit junk_high = 1'b0;

   dual_lfo_with_sync_delay_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_noise       (req_noise),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pitch_value (rsp_pitch_value),
      .rsp_amp_value   (rsp_amp_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   function automatic int pitch_shape();
      int p;
      int v;
      p = int'(pitch_acc[31:16]);
      case (lfo_cfg.pitch_wave)
         WAVE_SAW:    return (p >= FULL_SCALE) ? p - 2 * FULL_SCALE : p;
         WAVE_SQUARE: return (p < FULL_SCALE) ? FULL_SCALE - 1 : -FULL_SCALE;
         WAVE_TRIANGLE: begin
            if (p < FULL_SCALE / 2)
               v = 2 * p;
            else if (p < 3 * FULL_SCALE / 2)
               v = FULL_SCALE - 2 * (p - FULL_SCALE / 2);
            else
               v = -FULL_SCALE + 2 * (p - 3 * FULL_SCALE / 2);
            return (v > FULL_SCALE - 1) ? FULL_SCALE - 1 : v;
         end
         WAVE_NOISE:  return int'(noise_hold);
         default:     return 0;
      endcase
   endfunction

   function automatic int amp_shape();
      int p;
      p = int'(amp_acc[31:17]);
      case (lfo_cfg.amp_wave)
         WAVE_SAW:      return FULL_SCALE - p;
         WAVE_SQUARE:   return (p < FULL_SCALE / 2) ? FULL_SCALE : 0;
         WAVE_TRIANGLE: return (p < FULL_SCALE / 2) ? FULL_SCALE - 2 * p
                                                    : 2 * (p - FULL_SCALE / 2);
         WAVE_NOISE:    return (int'(noise_hold) + FULL_SCALE) / 2;
         default:       return 0;
      endcase
   endfunction

   // Advance the predicted oscillator by one accepted item
   function automatic void advance_lfo(input logic cmd, input logic signed [15:0] noise);
      logic [32:0] pitch_sum;
      logic [32:0] amp_sum;
      logic [1:0]  mode;
      int          pv;
      int          target;
      int          rate;
      lfo_mod_t    mod;
      pv = 0;
      target = 0;
      if (cmd == CMD_NOTE) begin
         mode = (lfo_cfg.sync_mode == SYNC_SPARE) ? SYNC_DELAYED : lfo_cfg.sync_mode;
         if (mode != SYNC_FREE
             || lfo_cfg.pitch_wave == WAVE_ONESHOT_A || lfo_cfg.pitch_wave == WAVE_ONESHOT_B
             || lfo_cfg.amp_wave == WAVE_ONESHOT_A || lfo_cfg.amp_wave == WAVE_ONESHOT_B) begin
            pitch_acc = '0;
            amp_acc = '0;
         end
         sync_wait = (mode == SYNC_DELAYED) ? lfo_cfg.delay_ticks : '0;
         return;
      end
      if (lfo_cfg.enables != 2'b00) begin
         if (sync_wait != '0)
            sync_wait = sync_wait - 1'b1;
         if (sync_wait == '0) begin
            pitch_sum = {1'b0, pitch_acc} + {1'b0, lfo_cfg.pitch_step};
            amp_sum = {1'b0, amp_acc} + {1'b0, lfo_cfg.amp_step};
            pitch_acc = pitch_sum[31:0];
            amp_acc = amp_sum[31:0];
            if (pitch_sum[32] || amp_sum[32])
               noise_hold = noise;
            pv = pitch_shape();
            target = amp_shape();
         end
      end
      rate = (lfo_cfg.smooth_rate > RATE_UNITY) ? int'(RATE_UNITY) : int'(lfo_cfg.smooth_rate);
      amp_level = amp_level + ((target - amp_level) * rate) / FULL_SCALE;
      mod.pitch = pv[15:0];
      mod.amp = amp_level[15:0];
      mod_expected.push_back(mod);
   endfunction

   // Driver: offer the oldest pending item, with random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_lfo(req_cmd, req_noise);
            void'(req_pending.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the item until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_pending.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_cmd <= req_pending[0].cmd;
            req_noise <= req_pending[0].noise;
         end
      end
   end

   // Monitor: compare each result with the oldest prediction, stall at random
   always @(posedge clock) begin
      lfo_mod_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mod_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected item pitch %0d amp %0d",
                                      rsp_pitch_value, rsp_amp_value));
         end else begin
            want = mod_expected.pop_front();
            if (rsp_pitch_value !== want.pitch)
               report_mismatch($sformatf("pitch_value %0d, predicted %0d",
                                         rsp_pitch_value, $signed(want.pitch)));
            if (rsp_amp_value !== want.amp)
               report_mismatch($sformatf("amp_value %0d, predicted %0d",
                                         rsp_amp_value, want.amp));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] keep;
      logic [31:0] data;
      case (idx)
         CSR_ENABLES:     keep = 32'h0000_0003;
         CSR_PITCH_WAVE:  keep = 32'h0000_0007;
         CSR_AMP_WAVE:    keep = 32'h0000_0007;
         CSR_PITCH_STEP:  keep = 32'hFFFF_FFFF;
         CSR_AMP_STEP:    keep = 32'hFFFF_FFFF;
         CSR_SYNC_MODE:   keep = 32'h0000_0003;
         CSR_DELAY_TICKS: keep = 32'h00FF_FFFF;
         CSR_SMOOTH_RATE: keep = 32'h0000_FFFF;
      endcase
      data = value & keep;
      // scatter junk above the field, which the register must drop
      if (junk_high)
         data = data | ($urandom & ~keep);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLES:     lfo_cfg.enables = data[1:0];
         CSR_PITCH_WAVE:  lfo_cfg.pitch_wave = data[2:0];
         CSR_AMP_WAVE:    lfo_cfg.amp_wave = data[2:0];
         CSR_PITCH_STEP:  lfo_cfg.pitch_step = data;
         CSR_AMP_STEP:    lfo_cfg.amp_step = data;
         CSR_SYNC_MODE:   lfo_cfg.sync_mode = data[1:0];
         CSR_DELAY_TICKS: lfo_cfg.delay_ticks = data[23:0];
         CSR_SMOOTH_RATE: lfo_cfg.smooth_rate = data[15:0];
      endcase
   endtask

   task automatic set_all(input logic [1:0] en, input logic [2:0] pw, input logic [2:0] aw,
                          input logic [31:0] ps, input logic [31:0] as_step,
                          input logic [1:0] sm, input logic [23:0] dt, input logic [15:0] sr);
      write_reg(CSR_ENABLES, en);
      write_reg(CSR_PITCH_WAVE, pw);
      write_reg(CSR_AMP_WAVE, aw);
      write_reg(CSR_PITCH_STEP, ps);
      write_reg(CSR_AMP_STEP, as_step);
      write_reg(CSR_SYNC_MODE, sm);
      write_reg(CSR_DELAY_TICKS, dt);
      write_reg(CSR_SMOOTH_RATE, sr);
      csr_valid <= 1'b0;
   endtask

   function automatic void push_item(input logic cmd, input logic [15:0] noise);
      lfo_req_t item;
      item.cmd = cmd;
      item.noise = noise;
      req_pending.push_back(item);
   endfunction

   // Wait until every item is taken and every result is back, then let a note-on settle
   task automatic drain();
      do @(posedge clock); while (req_pending.size() != 0 || mod_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return $urandom >> $urandom_range(4, 16);
         2:       return 32'h4000_0000 * $urandom_range(0, 3);
         3:       return ~$urandom_range(0, 255);
         default: return $urandom_range(1, 65535);
      endcase
   endfunction

   initial begin
      int          set_no;
      int          k;
      logic [1:0]  en;
      logic [23:0] dt;
      logic [15:0] sr;
      lfo_cfg = '0;
      lfo_cfg.smooth_rate = RATE_UNITY;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: both oscillators off, output decays to zero
      push_item(CMD_TICK, 16'h7FFF);
      push_item(CMD_TICK, 16'h8000);
      drain();

      set_all(2'b11, WAVE_SAW, WAVE_SAW, 32'h1000_0000, 32'h0800_0000,
              SYNC_ON_NOTE, 24'd0, RATE_UNITY);
      push_item(CMD_NOTE, 16'h0000);
      push_item(CMD_TICK, 16'h7FFF);
      push_item(CMD_TICK, 16'h8000);
      push_item(CMD_TICK, 16'hFFFF);
      drain();

      // sync delay counts down before the phases move; rate above unity saturates
      set_all(2'b01, WAVE_TRIANGLE, WAVE_TRIANGLE, 32'hFFFF_FFFF, 32'h0000_0000,
              SYNC_DELAYED, 24'd3, 16'hFFFF);
      push_item(CMD_NOTE, 16'h1234);
      repeat (5) push_item(CMD_TICK, 16'h8000);
      drain();

      // spare sync code behaves as delayed sync; noise held on each wrap
      set_all(2'b10, WAVE_NOISE, WAVE_NOISE, 32'h8000_0000, 32'hC000_0000,
              SYNC_SPARE, 24'd1, 16'd0);
      push_item(CMD_NOTE, 16'h0000);
      push_item(CMD_TICK, 16'h7FFF);
      push_item(CMD_TICK, 16'h8000);
      push_item(CMD_TICK, 16'h0001);
      drain();

      // free run with one-shot codes: a note-on still resets the phases
      set_all(2'b11, WAVE_ONESHOT_A, WAVE_ONESHOT_B, 32'h0000_0001, 32'h0001_0000,
              SYNC_FREE, 24'hFF_FFFF, 16'd1);
      push_item(CMD_TICK, 16'h5555);
      push_item(CMD_NOTE, 16'hAAAA);
      push_item(CMD_TICK, 16'h5555);
      drain();

      // free run without one-shot codes: a note-on leaves the phases alone
      set_all(2'b11, WAVE_SQUARE, WAVE_SQUARE, 32'h4000_0000, 32'h4000_0000,
              SYNC_FREE, 24'd0, 16'd16384);
      push_item(CMD_TICK, 16'h0000);
      push_item(CMD_NOTE, 16'h0000);
      push_item(CMD_TICK, 16'hFFFF);
      push_item(CMD_TICK, 16'h7FFF);

      for (set_no = 0; set_no < RANDOM_SETS; set_no++) begin
         drain();
         calm = (set_no == RANDOM_SETS / 2 || set_no == RANDOM_SETS - 1);
         junk_high = 1'b1;
         en = ($urandom_range(0, 7) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
         case ($urandom_range(0, 7))
            0:       dt = 24'hFF_FFFF;
            1:       dt = '0;
            default: dt = 24'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 5))
            0:       sr = RATE_UNITY;
            1:       sr = 16'hFFFF;
            2:       sr = '0;
            default: sr = 16'($urandom_range(1, 32768));
         endcase
         set_all(en, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_step(),
                 pick_step(), 2'($urandom_range(0, 3)), dt, sr);
         push_item(CMD_NOTE, 16'($urandom));
         for (k = 1; k < SET_ITEMS; k++)
            push_item(($urandom_range(0, 11) == 0) ? CMD_NOTE : CMD_TICK, 16'($urandom));
      end

      drain();
      repeat (10) @(posedge clock);
      if (mod_expected.size() != 0)
         report_mismatch($sformatf("%0d predicted items never arrived", mod_expected.size()));
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
